FILE: sv/lcls_pkg.sv
// ----------------------------------------------------------------------------
// lcls_pkg: shared definitions for the led cube layer serializer
// Driver chain geometry, operation and register codes, and the control
// structs passed between the sequencer, the voxel ram and the output stage.
// ----------------------------------------------------------------------------
package lcls_pkg;

  localparam int DRIVER_COUNT    = 5;
  localparam int GRAY_BITS       = 12;
  localparam int DC_WORD_BITS    = 6;
  localparam int CH_PER_DRIVER   = 16;
  localparam int SLOT_COUNT      = DRIVER_COUNT * CH_PER_DRIVER;
  localparam int SLOT_W          = $clog2(SLOT_COUNT + 1);
  localparam int SUB_W           = $clog2(GRAY_BITS);
  localparam int VOXEL_SLOTS     = 64;
  localparam int LAYER_SLOT_BASE = 72;
  localparam int ROW_W           = 6;
  localparam int CFG_DATA_W      = 8;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 16;

  localparam logic [CFG_DATA_W-1:0]   THRESHOLD_RESET = 8'd125;
  localparam logic [DC_WORD_BITS-1:0] DC_LEVEL_RESET  = 6'd63;

  localparam logic CFG_ON_THRESHOLD = 1'b0;
  localparam logic CFG_DC_LEVEL     = 1'b1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic {
    PH_DOT  = 1'b0,
    PH_GRAY = 1'b1
  } phase_t;

  typedef struct packed {
    logic       use_voxel;
    logic       const_bit;
    logic [2:0] z;
    logic       sclk;
    logic       gsclk;
    logic       xlat;
    logic       blank;
    logic       vprg;
    logic [2:0] layer;
    logic       fend;
  } ctrl_t;

  typedef struct packed {
    logic             re;
    logic [ROW_W-1:0] row;
  } rd_req_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] row;
    logic [2:0]       z;
    logic             value;
  } wr_req_t;

endpackage

FILE: sv/lcls_seq.sv
// ----------------------------------------------------------------------------
// lcls_seq: serial sequencer
// Tracks dot correction and grayscale layers, and builds the pin levels and
// the voxel read for each tick request.
// ----------------------------------------------------------------------------
module lcls_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick,
  input  logic [lcls_pkg::DC_WORD_BITS-1:0]   dc_level,
  output lcls_pkg::ctrl_t                     ctrl,
  output lcls_pkg::rd_req_t                   rd
);
  import lcls_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [SUB_W-1:0]  sub;
  logic [SUB_W-1:0]  sub_next;
  logic [2:0]        layer_idx;
  logic [2:0]        layer_idx_next;
  logic              first_flag;
  logic              first_flag_next;
  logic              vprg_level;
  logic              vprg_level_next;

  logic              slot_end;
  logic              sub_last;
  logic [2:0]        dc_idx;
  logic [3:0]        r;
  logic [SLOT_W-1:0] layer_slot;

  assign slot_end   = (slot == SLOT_W'(SLOT_COUNT));
  assign dc_idx     = 3'(DC_WORD_BITS - 1) - sub[2:0];
  assign r          = slot[3:0];
  assign layer_slot = SLOT_W'(LAYER_SLOT_BASE) + SLOT_W'(layer_idx);
  assign sub_last   = (phase == PH_DOT) ? (sub == SUB_W'(DC_WORD_BITS - 1))
                                        : (sub == SUB_W'(GRAY_BITS - 1));

  always_comb begin
    phase_next      = phase;
    slot_next       = slot;
    sub_next        = sub;
    layer_idx_next  = layer_idx;
    first_flag_next = first_flag;
    vprg_level_next = vprg_level;
    case (phase)
      PH_DOT: begin
        if (!slot_end) begin
          if (sub_last) begin
            sub_next  = '0;
            slot_next = slot + 1'b1;
          end else begin
            sub_next = sub + 1'b1;
          end
        end else begin
          slot_next  = '0;
          sub_next   = '0;
          phase_next = PH_GRAY;
        end
      end
      default: begin
        // first grayscale tick after dot correction drops vprg
        if (slot == '0 && sub == '0 && vprg_level) begin
          vprg_level_next = 1'b0;
          first_flag_next = 1'b1;
        end
        if (!slot_end) begin
          if (sub_last) begin
            sub_next  = '0;
            slot_next = slot + 1'b1;
          end else begin
            sub_next = sub + 1'b1;
          end
        end else begin
          first_flag_next = 1'b0;
          slot_next       = '0;
          sub_next        = '0;
          layer_idx_next  = layer_idx + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    ctrl       = '0;
    ctrl.blank = 1'b1;
    ctrl.vprg  = vprg_level;
    ctrl.z     = ~layer_idx;
    case (phase)
      PH_DOT: begin
        if (!slot_end) begin
          ctrl.const_bit = dc_level[dc_idx];
          ctrl.sclk      = 1'b1;
        end else begin
          ctrl.const_bit = dc_level[0];
          ctrl.xlat      = 1'b1;
          ctrl.fend      = 1'b1;
        end
      end
      default: begin
        ctrl.vprg  = vprg_level_next;
        ctrl.layer = layer_idx;
        if (!slot_end) begin
          ctrl.sclk      = 1'b1;
          ctrl.gsclk     = 1'b1;
          ctrl.blank     = 1'b0;
          ctrl.use_voxel = (slot < SLOT_W'(VOXEL_SLOTS));
          ctrl.const_bit = (slot == layer_slot);
        end else begin
          ctrl.const_bit = (SLOT_W'(SLOT_COUNT - 1) == layer_slot);
          ctrl.xlat      = 1'b1;
          ctrl.fend      = 1'b1;
          ctrl.sclk      = first_flag;
        end
      end
    endcase
    // serpentine pin map: even r runs up the row, odd r runs back
    rd.re  = tick && ctrl.use_voxel;
    rd.row = {slot[5:4], r[0], (r[0] ? ~r[3:1] : r[3:1])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DOT;
      slot       <= '0;
      sub        <= '0;
      layer_idx  <= '0;
      first_flag <= 1'b0;
      vprg_level <= 1'b1;
    end else if (tick) begin
      phase      <= phase_next;
      slot       <= slot_next;
      sub        <= sub_next;
      layer_idx  <= layer_idx_next;
      first_flag <= first_flag_next;
      vprg_level <= vprg_level_next;
    end
  end

`ifndef SYNTHESIS
  a_phase_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GRAY |=> phase == PH_GRAY)
    else $error("sequencer returned to dot correction");
  a_vprg_gray: assert property (@(posedge clk) disable iff (rst)
    !vprg_level |-> phase == PH_GRAY)
    else $error("vprg low outside grayscale");
  a_latch_restart: assert property (@(posedge clk) disable iff (rst)
    tick && ctrl.xlat |=> slot == '0 && sub == '0)
    else $error("counters not restarted after latch");
  a_first_flag: assert property (@(posedge clk) disable iff (rst)
    first_flag |-> !vprg_level)
    else $error("first layer flag set while vprg high");
`endif

endmodule

FILE: sv/lcls_vox_ram.sv
// ----------------------------------------------------------------------------
// lcls_vox_ram: voxel on/off memory
// 64 rows of 8 height bits, one write and one registered read port, with a
// clearing pass of one row per cycle after reset.
// ----------------------------------------------------------------------------
module lcls_vox_ram (
  input  logic               clk,
  input  logic               rst,
  input  lcls_pkg::wr_req_t  wr,
  input  lcls_pkg::rd_req_t  rd,
  output logic [7:0]         rd_data,
  output logic               busy
);
  import lcls_pkg::*;

  logic [7:0]       mem [2**ROW_W];
  logic [ROW_W-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == {ROW_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_row] <= '0;
    end else if (wr.we) begin
      mem[wr.row][wr.z] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data <= mem[rd.row];
    end
  end

`ifndef SYNTHESIS
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr.we)
    else $error("voxel write during clearing pass");
  a_no_read_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !rd.re)
    else $error("voxel read during clearing pass");
  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(clr_row) == {ROW_W{1'b1}})
    else $error("clearing pass ended early");
`endif

endmodule

FILE: sv/lcls_out.sv
// ----------------------------------------------------------------------------
// lcls_out: pin stage and output register
// Holds a tick's control word beside the voxel read, selects the serial bit
// and packs the pin levels into the result register.
// ----------------------------------------------------------------------------
module lcls_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tick,
  input  lcls_pkg::ctrl_t                    ctrl_in,
  input  logic [7:0]                         rd_data,
  output logic                               s1_free,
  input  logic                               m_axis_tready,
  output logic                               m_axis_tvalid,
  output logic [lcls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import lcls_pkg::*;

  logic  s1_valid;
  ctrl_t s1_ctrl;
  logic  s1_advance;
  logic  sin;

  assign s1_advance = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s1_free    = !s1_valid || s1_advance;
  assign sin        = s1_ctrl.use_voxel ? rd_data[s1_ctrl.z] : s1_ctrl.const_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_axis_tdata <= {6'd0, s1_ctrl.layer, 1'b1, s1_ctrl.vprg, s1_ctrl.blank,
                       s1_ctrl.xlat, s1_ctrl.gsclk, s1_ctrl.sclk, sin};
      m_axis_tlast <= s1_ctrl.fend;
    end
  end

endmodule

FILE: sv/led_cube_layer_serializer_top.sv
// ----------------------------------------------------------------------------
// led_cube_layer_serializer_top: led cube driver chain serializer
// Stores one on/off bit per voxel and produces, per tick, the serial data,
// clock, latch and blank levels for a chain of constant-current drivers.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: tuser selects a voxel write or a tick; tdata holds
//   the voxel position and level. a write produces no result, a tick produces
//   one result on m_axis with the pin levels; tlast marks the latch tick that
//   ends dot correction or a layer.
//   cfg_wen/cfg_index/cfg_data write the on threshold and the dot correction
//   word; write them only while the block is idle.
//   a tick result passes the pin stage and then the result register; one
//   request per cycle is accepted while m_axis_tready stays high.
//   after reset the voxel ram is cleared one row per cycle, all 64 rows, with
//   s_axis_tready low, then dot correction starts with the first tick.
//   when m_axis_tready is low the result register holds and one more tick
//   request is taken into the pin stage before s_axis_tready drops.
// ----------------------------------------------------------------------------
module led_cube_layer_serializer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_pos[2:0], y_pos[5:3], z_pos[8:6], level[16:9]
  input  logic [lcls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // serial_in, shift_clock, gray_clock, latch, blank, prog_select, dc_prog,
  // layer[9:7]
  output logic [lcls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // frame_end
  output logic                                m_axis_tlast,
  input  logic                                cfg_wen,
  input  logic                                cfg_index,
  input  logic [lcls_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lcls_pkg::*;

  logic [CFG_DATA_W-1:0]   on_threshold;
  logic [DC_WORD_BITS-1:0] dc_level;

  logic       accept;
  logic       tick;
  logic       s1_free;
  logic       busy;
  logic [7:0] rd_data;
  ctrl_t      ctrl;
  rd_req_t    rd;
  wr_req_t    wr;

  assign s_axis_tready = s1_free && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick          = accept && (s_axis_tuser == OP_TICK);

  assign wr.we    = accept && (s_axis_tuser == OP_WRITE);
  assign wr.row   = {s_axis_tdata[2:0], s_axis_tdata[5:3]};
  assign wr.z     = s_axis_tdata[8:6];
  assign wr.value = (s_axis_tdata[16:9] > on_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold <= THRESHOLD_RESET;
      dc_level     <= DC_LEVEL_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_ON_THRESHOLD: on_threshold <= cfg_data;
        CFG_DC_LEVEL:     dc_level     <= cfg_data[DC_WORD_BITS-1:0];
        default:          ;
      endcase
    end
  end

  lcls_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .dc_level (dc_level),
    .ctrl     (ctrl),
    .rd       (rd)
  );

  lcls_vox_ram u_vox_ram (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data),
    .busy    (busy)
  );

  lcls_out u_out (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .ctrl_in       (ctrl),
    .rd_data       (rd_data),
    .s1_free       (s1_free),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
